>>> hw/rtl/drse_pkg.sv
// Shared constants, types and codes of the deletion-resilient stream encoder.
`default_nettype none

package drse_pkg;

  // Redundancy bits per coded byte; the remaining top bits carry data.
  localparam int unsigned REDUNDANCY_BITS = 7;
  localparam int unsigned RC_BITS         = 8 - REDUNDANCY_BITS;
  localparam int unsigned CHUNKS          = 8 / RC_BITS;
  localparam int unsigned CHUNK_CNT_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam int unsigned STATE_W     = 64;
  localparam int unsigned TABLE_WORDS = 4;
  localparam int unsigned CFG_ADDR_W  = $clog2(TABLE_WORDS);

  // Depths of the request queue and the result queue.
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int unsigned RES_DEPTH  = 2;
  localparam int unsigned RES_PTR_W  = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int unsigned RES_CNT_W  = $clog2(RES_DEPTH + 1);

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_CHECK  = 1'b1;

  typedef struct packed {
    logic       func;
    logic       start_req;
    logic [7:0] data_byte;
  } drse_cmd_t;

  typedef struct packed {
    logic [7:0]         code_byte;
    logic               last;
    logic               check_ok;
    logic               decoded_valid;
    logic [7:0]         decoded_byte;
    logic [STATE_W-1:0] coder_state;
  } drse_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/drse_front.sv
// Front end: accepts requests and holds them in a short queue for the back end.
`default_nettype none

module drse_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              func_i,
  input  wire logic              start_req_i,
  input  wire logic [7:0]        data_byte_i,
  output logic                   cmd_valid_o,
  output drse_pkg::drse_cmd_t    cmd_o,
  input  wire logic              cmd_pop_i
);
  import drse_pkg::*;

  drse_cmd_t              mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0]   count_q, count_d;
  logic                   do_push, do_pop;
  drse_cmd_t              cmd_in;

  assign full        = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // The function bit decides whether the back end encodes or checks the request.
  always_comb begin
    cmd_in.func      = (func_i == FUNC_CHECK) ? FUNC_CHECK : FUNC_ENCODE;
    cmd_in.start_req = start_req_i;
    cmd_in.data_byte = data_byte_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/drse_back.sv
// Back end: coder state, transition table and one coded byte per cycle unless stalled.
`default_nettype none

module drse_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [drse_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [drse_pkg::STATE_W-1:0]        cfg_wdata_i,
  input  wire logic                                cmd_valid_i,
  input  drse_pkg::drse_cmd_t                      cmd_i,
  output logic                                     cmd_pop_o,
  input  wire logic                                res_ready_i,
  output logic                                     res_valid_o,
  output drse_pkg::drse_res_t                      res_o
);
  import drse_pkg::*;

  logic [STATE_W-1:0]     table_q [TABLE_WORDS];
  logic [STATE_W-1:0]     state_q, state_d;
  logic [7:0]             bbuf_q, bbuf_d;
  logic [2:0]             bcnt_q, bcnt_d;
  logic [CHUNK_CNT_W-1:0] chunk_q, chunk_d;

  logic                   fire, is_check, clear, last;
  logic [STATE_W-1:0]     st_cur, tword, xval;
  logic [7:0]             buf_cur;
  logic [2:0]             cnt_cur;
  logic [3:0]             sh_amt;
  logic [7:0]             enc_shifted;
  logic [RC_BITS-1:0]     chunk;
  logic [7:0]             chunk_ext;
  logic [1:0]             sel;
  logic [15:0]            merged;
  logic [3:0]             nsum;
  logic                   dv;

  assign fire     = cmd_valid_i && res_ready_i;
  assign is_check = (cmd_i.func == FUNC_CHECK);
  // A start request clears the state only ahead of the first coded byte.
  assign clear    = cmd_i.start_req && (chunk_q == '0);
  assign st_cur   = clear ? '0 : state_q;
  assign buf_cur  = clear ? '0 : bbuf_q;
  assign cnt_cur  = clear ? '0 : bcnt_q;

  assign sh_amt      = 4'(chunk_q) * 4'(RC_BITS);
  assign enc_shifted = cmd_i.data_byte >> sh_amt;
  assign chunk       = is_check ? cmd_i.data_byte[7:REDUNDANCY_BITS]
                                : enc_shifted[RC_BITS-1:0];
  assign chunk_ext   = 8'(chunk);
  assign sel         = chunk_ext[1:0];
  assign tword       = table_q[sel];
  assign xval        = st_cur ^ tword;

  // Check mode appends the data bits of the coded byte to the bit buffer.
  assign merged = {8'h00, buf_cur} | (16'(chunk) << cnt_cur);
  assign nsum   = {1'b0, cnt_cur} + 4'(RC_BITS);
  assign dv     = is_check && nsum[3];

  assign last        = is_check || (chunk_q == CHUNK_CNT_W'(CHUNKS - 1));
  assign cmd_pop_o   = fire && last;
  assign res_valid_o = fire;

  always_comb begin
    res_o.code_byte     = is_check ? cmd_i.data_byte
                                   : {chunk, xval[REDUNDANCY_BITS-1:0]};
    res_o.last          = last;
    res_o.check_ok      = is_check &&
                          (cmd_i.data_byte[REDUNDANCY_BITS-1:0] ==
                           xval[REDUNDANCY_BITS-1:0]);
    res_o.decoded_valid = dv;
    res_o.decoded_byte  = dv ? merged[7:0] : 8'h00;
    res_o.coder_state   = state_d;
  end

  always_comb begin
    state_d = (xval >> REDUNDANCY_BITS) | (st_cur << (STATE_W - REDUNDANCY_BITS));
    bbuf_d  = bbuf_q;
    bcnt_d  = bcnt_q;
    chunk_d = chunk_q;
    if (fire) begin
      chunk_d = last ? '0 : chunk_q + 1'b1;
      if (is_check) begin
        bbuf_d = dv ? merged[15:8] : merged[7:0];
        bcnt_d = nsum[2:0];
      end else if (clear) begin
        bbuf_d = '0;
        bcnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      bbuf_q  <= '0;
      bcnt_q  <= '0;
      chunk_q <= '0;
      for (int i = 0; i < TABLE_WORDS; i++) begin
        table_q[i] <= '0;
      end
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      bbuf_q  <= bbuf_d;
      bcnt_q  <= bcnt_d;
      chunk_q <= chunk_d;
      if (cfg_we_i) begin
        table_q[cfg_addr_i] <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/drse_res_queue.sv
// Result queue: holds finished results until the consumer pops them.
`default_nettype none

module drse_res_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            res_valid_i,
  input  drse_pkg::drse_res_t  res_i,
  output logic                 res_ready_o,
  output logic                 empty,
  input  wire logic            pop,
  output drse_pkg::drse_res_t  res_o
);
  import drse_pkg::*;

  drse_res_t              mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0]   count_q, count_d;
  logic                   do_push, do_pop;

  assign res_ready_o = (count_q != RES_CNT_W'(RES_DEPTH));
  assign empty       = (count_q == '0);
  assign res_o       = mem_q[rd_ptr_q];
  assign do_push     = res_valid_i && res_ready_o;
  assign do_pop      = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/deletion_resilient_stream_encoder.sv
// Top level of the deletion-resilient stream encoder and checker.
//
//   channel   direction  handshake              payload
//   request   in         push / full            func_i, start_req_i, data_byte_i
//   result    out        empty / pop            code_byte_o .. coder_state_out_o
//   config    in         cfg_we_i (no wait)     cfg_addr_i, cfg_wdata_i
//
// An encode request yields 8 / (8 - REDUNDANCY_BITS) results, one per cycle while
// the result queue has room, and holds the back end until its last one; a check
// request yields one result. A request passes from the request queue through the
// combinational back end into the result queue. The back end produces one coded
// byte per cycle, unless stalled, through its 64-bit state update. Reset clears
// the coder state, bit buffer, table words and both queues. A full result queue
// stalls the back end; the request queue keeps accepting until it fills.
`default_nettype none

module deletion_resilient_stream_encoder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic                             func_i,
  input  wire logic                             start_req_i,
  input  wire logic [7:0]                       data_byte_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [7:0]                            code_byte_o,
  output logic                                  last_o,
  output logic                                  check_ok_o,
  output logic                                  decoded_valid_o,
  output logic [7:0]                            decoded_byte_o,
  output logic [drse_pkg::STATE_W-1:0]          coder_state_out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [drse_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [drse_pkg::STATE_W-1:0]     cfg_wdata_i
);
  import drse_pkg::*;

  logic      cmd_valid, cmd_pop;
  drse_cmd_t cmd;
  logic      res_valid, res_ready;
  drse_res_t res_in, res_out;

  drse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .start_req_i (start_req_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  drse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res_in)
  );

  drse_res_queue u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_in),
    .res_ready_o (res_ready),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_out)
  );

  assign code_byte_o       = res_out.code_byte;
  assign last_o            = res_out.last;
  assign check_ok_o        = res_out.check_ok;
  assign decoded_valid_o   = res_out.decoded_valid;
  assign decoded_byte_o    = res_out.decoded_byte;
  assign coder_state_out_o = res_out.coder_state;

endmodule

`default_nettype wire

>>> hw/rtl/drse_checker.sv
// Port-level checker for the stream encoder, bound to the top level.
`default_nettype none

module drse_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             empty,
  input wire logic                             pop,
  input wire logic [7:0]                       code_byte_o,
  input wire logic                             last_o,
  input wire logic                             check_ok_o,
  input wire logic                             decoded_valid_o,
  input wire logic [7:0]                       decoded_byte_o
);

  // A waiting result does not vanish without a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result withdrawn without a pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(code_byte_o) && $stable(last_o))
    else $error("waiting result changed");

  // Only encode requests produce several results, and they never report checks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !last_o |-> !check_ok_o && !decoded_valid_o)
    else $error("non-final result carries check status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !decoded_valid_o |-> decoded_byte_o == 8'h00)
    else $error("decoded byte set without a decoded byte");

endmodule

bind deletion_resilient_stream_encoder drse_checker u_drse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .code_byte_o     (code_byte_o),
  .last_o          (last_o),
  .check_ok_o      (check_ok_o),
  .decoded_valid_o (decoded_valid_o),
  .decoded_byte_o  (decoded_byte_o)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the deletion-resilient stream encoder and checker.
`timescale 1ns / 100ps

module tb;
  import drse_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] TBL_WORD_0 = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] TBL_WORD_1 = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] TBL_WORD_2 = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] TBL_WORD_3 = CFG_ADDR_W'(3);

  localparam logic [STATE_W-1:0] RED_MASK   = (64'd1 << REDUNDANCY_BITS) - 64'd1;
  localparam int unsigned        CHUNK_MASK = (1 << RC_BITS) - 1;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  push            = 1'b0;
  logic                  func_i          = FUNC_ENCODE;
  logic                  start_req_i     = 1'b0;
  logic [7:0]            data_byte_i     = 8'h00;
  logic                  pop             = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i      = TBL_WORD_0;
  logic [STATE_W-1:0]    cfg_wdata_i     = '0;
  logic                  full;
  logic                  empty;
  logic [7:0]            code_byte_o;
  logic                  last_o;
  logic                  check_ok_o;
  logic                  decoded_valid_o;
  logic [7:0]            decoded_byte_o;
  logic [STATE_W-1:0]    coder_state_out_o;

  // Mirror of the coder: table words, running state and the pending data bits.
  logic [STATE_W-1:0] table_words [TABLE_WORDS];
  logic [STATE_W-1:0] model_state   = '0;
  logic [7:0]         pending_bits  = '0;
  int unsigned        pending_count = 0;

  drse_res_t   awaited_results [$];
  drse_res_t   oldest;
  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  deletion_resilient_stream_encoder u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .func_i            (func_i),
    .start_req_i       (start_req_i),
    .data_byte_i       (data_byte_i),
    .empty             (empty),
    .pop               (pop),
    .code_byte_o       (code_byte_o),
    .last_o            (last_o),
    .check_ok_o        (check_ok_o),
    .decoded_valid_o   (decoded_valid_o),
    .decoded_byte_o    (decoded_byte_o),
    .coder_state_out_o (coder_state_out_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < TABLE_WORDS; i++) table_words[i] = '0;
  end

  function automatic logic [STATE_W-1:0] advance_state(logic [STATE_W-1:0] s,
                                                       logic [STATE_W-1:0] t);
    logic [STATE_W-1:0] x;
    x = s ^ t;
    return (x >> REDUNDANCY_BITS) | (s << (STATE_W - REDUNDANCY_BITS));
  endfunction

  // Queues the results that one accepted request must produce.
  function automatic void compute_coder_results(logic f, logic s, logic [7:0] d);
    drse_res_t          r;
    logic [STATE_W-1:0] t;
    int unsigned        chunk;
    int unsigned        data_bits;
    int unsigned        n;
    int unsigned        acc;
    int                 k;
    if (s) begin
      model_state   = '0;
      pending_bits  = '0;
      pending_count = 0;
    end
    if (f == FUNC_ENCODE) begin
      for (k = 0; k < CHUNKS; k++) begin
        chunk = (32'(d) >> (k * RC_BITS)) & CHUNK_MASK;
        t = table_words[CFG_ADDR_W'(chunk)];
        r = '0;
        r.code_byte = 8'(chunk << REDUNDANCY_BITS) | 8'((model_state ^ t) & RED_MASK);
        model_state = advance_state(model_state, t);
        r.last = (k == CHUNKS - 1);
        r.coder_state = model_state;
        awaited_results.insert(awaited_results.size(), r);
      end
    end else begin
      r = '0;
      data_bits = 32'(d) >> REDUNDANCY_BITS;
      t = table_words[CFG_ADDR_W'(data_bits)];
      r.check_ok = (((STATE_W'(d)) ^ model_state ^ t) & RED_MASK) == '0;
      n = pending_count & 7;
      acc = 32'(pending_bits) | ((data_bits & CHUNK_MASK) << n);
      n += RC_BITS;
      if (n >= 8) begin
        r.decoded_valid = 1'b1;
        r.decoded_byte  = 8'(acc);
        acc = acc >> 8;
        n -= 8;
      end
      pending_bits  = 8'(acc);
      pending_count = n & 7;
      model_state   = advance_state(model_state, t);
      r.code_byte   = d;
      r.last        = 1'b1;
      r.coder_state = model_state;
      awaited_results.insert(awaited_results.size(), r);
    end
  endfunction

  // Coded byte that the checker accepts next for the given data bits.
  function automatic logic [7:0] matching_code(logic fresh, int unsigned bits);
    logic [STATE_W-1:0] s;
    s = fresh ? '0 : model_state;
    return 8'(bits << REDUNDANCY_BITS) |
           8'((s ^ table_words[CFG_ADDR_W'(bits)]) & RED_MASK);
  endfunction

  function automatic logic [STATE_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void compare_field(string name, logic [STATE_W-1:0] want,
                                        logic [STATE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Push stays high after acceptance so that back-to-back requests need no toggle.
  task automatic send_request(input logic f, input logic s, input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    func_i      <= f;
    start_req_i <= s;
    data_byte_i <= d;
    do @(posedge clk_i); while (full);
    compute_coder_results(f, s, d);
    requests_sent++;
  endtask

  task automatic wait_drained(input int unsigned settle_cycles);
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (settle_cycles) @(posedge clk_i);
  endtask

  task automatic load_tables(input logic [STATE_W-1:0] w0, input logic [STATE_W-1:0] w1,
                             input logic [STATE_W-1:0] w2, input logic [STATE_W-1:0] w3);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= TBL_WORD_0;
    cfg_wdata_i <= w0;
    @(posedge clk_i);
    cfg_addr_i  <= TBL_WORD_1;
    cfg_wdata_i <= w1;
    @(posedge clk_i);
    cfg_addr_i  <= TBL_WORD_2;
    cfg_wdata_i <= w2;
    @(posedge clk_i);
    cfg_addr_i  <= TBL_WORD_3;
    cfg_wdata_i <= w3;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_words[TBL_WORD_0] = w0;
    table_words[TBL_WORD_1] = w1;
    table_words[TBL_WORD_2] = w2;
    table_words[TBL_WORD_3] = w3;
  endtask

  // The table words still hold their reset value here.
  task automatic test_reset_tables();
    send_request(FUNC_ENCODE, 1'b1, 8'h00);
    send_request(FUNC_ENCODE, 1'b0, 8'hFF);
    send_request(FUNC_CHECK, 1'b0, 8'h00);
    send_request(FUNC_CHECK, 1'b0, 8'hFF);
    wait_drained(4);
  endtask

  task automatic test_extreme_tables();
    load_tables('1, '0, {32{2'b10}}, {32{2'b01}});
    send_request(FUNC_ENCODE, 1'b1, 8'hA5);
    send_request(FUNC_ENCODE, 1'b0, 8'h5A);
    send_request(FUNC_CHECK, 1'b0, 8'h80);
    send_request(FUNC_CHECK, 1'b1, 8'h7F);
    wait_drained(4);
  endtask

  // A clean check stream with an encode in the middle, which must not disturb
  // the pending data bits, followed by one corrupted coded byte.
  task automatic test_check_stream();
    int k;
    load_tables('0, '1, {32{2'b01}}, {32{2'b10}});
    for (k = 0; k < CHUNKS; k++) begin
      if (k == CHUNKS / 2) send_request(FUNC_ENCODE, 1'b0, 8'h3C);
      send_request(FUNC_CHECK, k == 0,
                   matching_code(k == 0, (32'hC3 >> (k * RC_BITS)) & CHUNK_MASK));
    end
    send_request(FUNC_CHECK, 1'b0, matching_code(1'b0, CHUNK_MASK) ^ 8'h01);
    wait_drained(4);
  endtask

  // Mostly well-formed check streams, some encode runs and some raw noise.
  task automatic test_random_stream(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    int unsigned bits;
    logic [7:0]  code;
    target = requests_sent + count;
    while (requests_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = $urandom_range(24, 8);
        for (int i = 0; i < len; i++) begin
          bits = $urandom_range(CHUNK_MASK, 0);
          code = matching_code(i == 0, bits);
          if ($urandom_range(99) < 5) code ^= 8'(1 << $urandom_range(7, 0));
          send_request(FUNC_CHECK, i == 0, code);
        end
      end else if (pick < 90) begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++)
          send_request(FUNC_ENCODE, $urandom_range(9) == 0, 8'($urandom));
      end else begin
        send_request(1'($urandom), 1'($urandom), 8'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, code_byte %h state %h", $time, code_byte_o,
                 coder_state_out_o);
        mismatches++;
      end else begin
        oldest = awaited_results.pop_front();
        compare_field("code_byte", STATE_W'(oldest.code_byte), STATE_W'(code_byte_o));
        compare_field("last", STATE_W'(oldest.last), STATE_W'(last_o));
        compare_field("check_ok", STATE_W'(oldest.check_ok), STATE_W'(check_ok_o));
        compare_field("decoded_valid", STATE_W'(oldest.decoded_valid),
                      STATE_W'(decoded_valid_o));
        compare_field("decoded_byte", STATE_W'(oldest.decoded_byte),
                      STATE_W'(decoded_byte_o));
        compare_field("coder_state", oldest.coder_state, coder_state_out_o);
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 14;
    recv_idle_pct = 84;
    test_reset_tables();
    test_extreme_tables();
    test_check_stream();
    load_tables(random_word(), random_word(), random_word(), random_word());
    test_random_stream(115);
    wait_drained(4);
    send_idle_pct = 84;
    recv_idle_pct = 14;
    load_tables(random_word(), '1, '0, random_word());
    test_random_stream(115);
    wait_drained(4);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_tables('0, random_word(), '1, random_word());
    test_random_stream(115);
    wait_drained(10);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
